[rtl/keyboard_console_buffer_unit_defines.svh]
// Assertion macros for the keyboard console buffer checker.
`ifndef KEYBOARD_CONSOLE_BUFFER_UNIT_DEFINES_SVH
`define KEYBOARD_CONSOLE_BUFFER_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define KCB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard console buffer check failed");

// Check a consequent in the cycle after its antecedent.
`define KCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard console buffer check failed");

`endif

[rtl/kcb_pkg.sv]
// Types, constants, key tables and helpers for the keyboard console buffer.
package kcb_pkg;

    localparam int RING_DEPTH    = 64;
    localparam int CONSOLE_COUNT = 12;
    localparam int PTR_W         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CON_W         = $clog2(CONSOLE_COUNT);
    localparam int NLC_W         = PTR_W;
    localparam int PLAIN_LEN     = 56;
    localparam int SHIFT_LEN     = 52;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CON_W-1:0] t_con;
    typedef logic [NLC_W-1:0] t_nlc;
    typedef logic [6:0]       t_chr;

    typedef enum logic [1:0] {
        CMD_EVENT    = 2'd0,
        CMD_POP_CHAR = 2'd1,
        CMD_POP_CODE = 2'd2,
        CMD_NONE     = 2'd3
    } t_command;

    localparam t_chr KEY_BREAK     = 7'd91;
    localparam t_chr KEY_F1        = 7'd59;
    localparam t_chr KEY_F10       = 7'd68;
    localparam t_chr KEY_BACKSPACE = 7'd14;
    localparam t_chr KEY_LSHIFT    = 7'd42;
    localparam t_chr KEY_RSHIFT    = 7'd54;
    localparam int   RELEASE_BIT   = 7;
    localparam t_chr ZERO_SHOWN    = 7'd64;
    localparam t_chr NEWLINE_CHAR  = 7'd10;
    localparam t_chr KEY_FIRST     = 7'd2;

    localparam t_chr PLAIN_MAP [PLAIN_LEN] = '{
        7'd38,  7'd0,   7'd34,  7'd39,  7'd40,  7'd45,  7'd0,
        7'd95,  7'd0,   7'd0,   7'd41,  7'd61,  7'd0,   7'd9,
        7'd97,  7'd122, 7'd101, 7'd114, 7'd116, 7'd121, 7'd117,
        7'd105, 7'd111, 7'd112, 7'd94,  7'd36,  7'd10,  7'd0,
        7'd113, 7'd115, 7'd100, 7'd102, 7'd103, 7'd104, 7'd106,
        7'd107, 7'd108, 7'd109, 7'd0,   7'd0,   7'd0,   7'd42,
        7'd119, 7'd120, 7'd99,  7'd118, 7'd98,  7'd110, 7'd44,
        7'd59,  7'd58,  7'd33,  7'd0,   7'd0,   7'd0,   7'd32
    };

    localparam t_chr SHIFT_MAP [SHIFT_LEN] = '{
        7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
        7'd56,  7'd57,  7'd48,  7'd0,   7'd43,  7'd0,   7'd9,
        7'd65,  7'd90,  7'd69,  7'd82,  7'd84,  7'd89,  7'd85,
        7'd73,  7'd79,  7'd80,  7'd0,   7'd0,   7'd10,  7'd0,
        7'd81,  7'd83,  7'd68,  7'd70,  7'd71,  7'd72,  7'd74,
        7'd75,  7'd76,  7'd77,  7'd37,  7'd0,   7'd0,   7'd0,
        7'd87,  7'd88,  7'd67,  7'd86,  7'd66,  7'd78,  7'd63,
        7'd46,  7'd47,  7'd0
    };

    typedef struct packed {
        logic en;
        t_con con;
        t_ptr tail;
        t_ptr prev;
    } t_rd_req;

    typedef struct packed {
        t_chr chr_tail;
        t_chr code_tail;
        t_chr chr_prev;
    } t_rd_data;

    typedef struct packed {
        logic en;
        t_con con;
        t_ptr slot;
        t_chr chr;
        t_chr code;
    } t_wr_req;

    function automatic t_ptr ptr_inc(input t_ptr p);
        return (p == t_ptr'(RING_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    function automatic t_ptr ptr_dec(input t_ptr p);
        return (p == '0) ? t_ptr'(RING_DEPTH - 1) : p - t_ptr'(1);
    endfunction

    function automatic t_chr translate(input t_chr code, input logic shift);
        t_chr idx;
        idx = code - KEY_FIRST;
        if (code < KEY_FIRST) begin
            return '0;
        end
        if (shift) begin
            return (idx < t_chr'(SHIFT_LEN)) ? SHIFT_MAP[idx[5:0]] : '0;
        end
        return (idx < t_chr'(PLAIN_LEN)) ? PLAIN_MAP[idx[5:0]] : '0;
    endfunction

endpackage

[rtl/kcb_ring_store.sv]
// Character and key code storage for all console rings.
module kcb_ring_store (
    input  logic             i_clk,
    input  kcb_pkg::t_rd_req i_rd_req,
    input  kcb_pkg::t_wr_req i_wr_req,
    output kcb_pkg::t_rd_data o_rd_data
);

    kcb_pkg::t_chr r_char_mem [kcb_pkg::CONSOLE_COUNT][kcb_pkg::RING_DEPTH];
    kcb_pkg::t_chr r_code_mem [kcb_pkg::CONSOLE_COUNT][kcb_pkg::RING_DEPTH];
    kcb_pkg::t_rd_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_req.en) begin
            r_char_mem[i_wr_req.con][i_wr_req.slot] <= i_wr_req.chr;
            r_code_mem[i_wr_req.con][i_wr_req.slot] <= i_wr_req.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_req.en) begin
            r_rd_data.chr_tail  <= r_char_mem[i_rd_req.con][i_rd_req.tail];
            r_rd_data.code_tail <= r_code_mem[i_rd_req.con][i_rd_req.tail];
            r_rd_data.chr_prev  <= r_char_mem[i_rd_req.con][i_rd_req.prev];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/keyboard_console_buffer_unit.sv]
// Top level of the keyboard console buffer: scancode decode and console rings.
//
// Channel   Direction  Handshake                    Payload
// request   in         start high, busy low         i_command, i_scancode,
//                                                   i_console_index, i_task_present
// result    out        o_result_strobe, one cycle   o_echo_* .. o_line_ready
//
// For each request the ring store is read at the accepting edge; the result is formed
// and the rings updated at the edge that ends the busy cycle.
// busy is high in the cycle after acceptance; the result strobe follows it,
// and a new request is taken at the edge that ends the strobe cycle.
// Synchronous active-low reset clears shift, active console, ring pointers and
// newline counts; stored characters need no clearing. The result side never stalls.
module keyboard_console_buffer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_command,
    input  logic [7:0] i_scancode,
    input  logic [3:0] i_console_index,
    input  logic       i_task_present,
    output logic       o_result_strobe,
    output logic       o_echo_valid,
    output logic [6:0] o_echo_char,
    output logic       o_erase_request,
    output logic       o_wake_reader,
    output logic       o_kill_request,
    output logic       o_switch_valid,
    output logic [3:0] o_switch_console,
    output logic       o_pop_valid,
    output logic [6:0] o_pop_data,
    output logic       o_line_ready
);

    logic r_shift;
    kcb_pkg::t_con r_active;
    kcb_pkg::t_ptr r_head [kcb_pkg::CONSOLE_COUNT];
    kcb_pkg::t_ptr r_tail [kcb_pkg::CONSOLE_COUNT];
    kcb_pkg::t_nlc r_nlc  [kcb_pkg::CONSOLE_COUNT];
    logic [kcb_pkg::CONSOLE_COUNT-1:0] r_line;
    logic r_busy;
    logic r_strobe;

    kcb_pkg::t_command r_cmd;
    kcb_pkg::t_chr     r_code;
    logic              r_rel;
    logic              r_task;
    kcb_pkg::t_con     r_con;
    logic              r_con_ok;
    kcb_pkg::t_ptr     r_hd;
    kcb_pkg::t_ptr     r_tl;
    kcb_pkg::t_nlc     r_nl;

    logic          r_echo_valid;
    kcb_pkg::t_chr r_echo_char;
    logic          r_erase;
    logic          r_wake;
    logic          r_kill;
    logic          r_switch_valid;
    logic [3:0]    r_switch_con;
    logic          r_pop_valid;
    kcb_pkg::t_chr r_pop_data;
    logic          r_line_ready;

    logic          n_shift;
    kcb_pkg::t_con n_active;
    kcb_pkg::t_ptr n_hd;
    kcb_pkg::t_ptr n_tl;
    kcb_pkg::t_nlc n_nl;
    logic          n_echo_valid;
    kcb_pkg::t_chr n_echo_char;
    logic          n_erase;
    logic          n_wake;
    logic          n_kill;
    logic          n_switch_valid;
    logic [3:0]    n_switch_con;
    logic          n_pop_valid;
    kcb_pkg::t_chr n_pop_data;
    logic          n_line_ready;

    logic              w_accept;
    logic              w_is_event;
    logic              w_is_pop;
    logic              w_idx_ok;
    kcb_pkg::t_con     w_con;
    kcb_pkg::t_chr     w_chr;
    kcb_pkg::t_rd_req  w_rd_req;
    kcb_pkg::t_wr_req  w_wr_req;
    kcb_pkg::t_rd_data w_rd_data;

    assign w_accept   = start && !r_busy;
    assign w_is_event = kcb_pkg::t_command'(i_command) == kcb_pkg::CMD_EVENT;
    assign w_is_pop   = (kcb_pkg::t_command'(i_command) == kcb_pkg::CMD_POP_CHAR) ||
                        (kcb_pkg::t_command'(i_command) == kcb_pkg::CMD_POP_CODE);
    assign w_idx_ok   = {1'b0, i_console_index} < 5'(kcb_pkg::CONSOLE_COUNT);
    assign w_con      = w_is_event ? r_active :
                        (w_idx_ok ? i_console_index[kcb_pkg::CON_W-1:0] : '0);

    always_comb begin
        w_rd_req.en   = w_accept;
        w_rd_req.con  = w_con;
        w_rd_req.tail = r_tail[w_con];
        w_rd_req.prev = kcb_pkg::ptr_dec(r_head[w_con]);
    end

    kcb_ring_store u_ring_store (
        .i_clk     (i_clk),
        .i_rd_req  (w_rd_req),
        .i_wr_req  (w_wr_req),
        .o_rd_data (w_rd_data)
    );

    assign w_chr = kcb_pkg::translate(r_code, r_shift);

    always_comb begin
        n_shift        = r_shift;
        n_active       = r_active;
        n_hd           = r_hd;
        n_tl           = r_tl;
        n_nl           = r_nl;
        n_echo_valid   = 1'b0;
        n_echo_char    = '0;
        n_erase        = 1'b0;
        n_wake         = 1'b0;
        n_kill         = 1'b0;
        n_switch_valid = 1'b0;
        n_switch_con   = '0;
        n_pop_valid    = 1'b0;
        n_pop_data     = '0;
        n_line_ready   = 1'b0;
        w_wr_req.en    = 1'b0;
        w_wr_req.con   = r_con;
        w_wr_req.slot  = r_hd;
        w_wr_req.chr   = w_chr;
        w_wr_req.code  = r_code;
        case (r_cmd)
            kcb_pkg::CMD_EVENT: begin
                if (r_code == kcb_pkg::KEY_LSHIFT || r_code == kcb_pkg::KEY_RSHIFT) begin
                    n_shift = !r_rel;
                end else if (!r_rel) begin
                    if (r_code == kcb_pkg::KEY_BREAK) begin
                        n_kill = r_task;
                    end else if (r_code >= kcb_pkg::KEY_F1 && r_code <= kcb_pkg::KEY_F10) begin
                        n_active       = kcb_pkg::t_con'(r_code - kcb_pkg::KEY_F1);
                        n_switch_valid = 1'b1;
                        n_switch_con   = 4'(r_code - kcb_pkg::KEY_F1);
                    end else if (r_code == kcb_pkg::KEY_BACKSPACE) begin
                        if (r_hd != r_tl) begin
                            if (w_rd_data.chr_prev == kcb_pkg::NEWLINE_CHAR && n_nl != '0) begin
                                n_nl = n_nl - kcb_pkg::t_nlc'(1);
                            end
                            n_hd    = kcb_pkg::ptr_dec(r_hd);
                            n_erase = 1'b1;
                        end
                    end else begin
                        // drop the oldest entry when the ring is full
                        if (kcb_pkg::ptr_inc(r_hd) == r_tl) begin
                            if (w_rd_data.chr_tail == kcb_pkg::NEWLINE_CHAR && n_nl != '0) begin
                                n_nl = n_nl - kcb_pkg::t_nlc'(1);
                            end
                            n_tl = kcb_pkg::ptr_inc(r_tl);
                        end
                        w_wr_req.en = 1'b1;
                        if (w_chr == kcb_pkg::NEWLINE_CHAR) begin
                            n_nl   = n_nl + kcb_pkg::t_nlc'(1);
                            n_wake = 1'b1;
                        end
                        n_hd         = kcb_pkg::ptr_inc(r_hd);
                        n_echo_valid = 1'b1;
                        n_echo_char  = (w_chr != '0) ? w_chr : kcb_pkg::ZERO_SHOWN;
                    end
                end
                n_line_ready = n_switch_valid ? r_line[n_active] : (n_nl != '0);
            end
            kcb_pkg::CMD_POP_CHAR, kcb_pkg::CMD_POP_CODE: begin
                if (r_con_ok) begin
                    if (r_hd != r_tl) begin
                        n_pop_valid = 1'b1;
                        n_pop_data  = (r_cmd == kcb_pkg::CMD_POP_CHAR) ?
                                      w_rd_data.chr_tail : w_rd_data.code_tail;
                        if (w_rd_data.chr_tail == kcb_pkg::NEWLINE_CHAR && n_nl != '0) begin
                            n_nl = n_nl - kcb_pkg::t_nlc'(1);
                        end
                        n_tl = kcb_pkg::ptr_inc(r_tl);
                    end
                    n_line_ready = n_nl != '0;
                end
            end
            default: begin
            end
        endcase
        w_wr_req.en = w_wr_req.en && r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_active <= '0;
            r_line   <= '0;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            for (int i = 0; i < kcb_pkg::CONSOLE_COUNT; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_nlc[i]  <= '0;
            end
        end else begin
            r_busy   <= w_accept;
            r_strobe <= r_busy;
            if (r_busy) begin
                r_shift  <= n_shift;
                r_active <= n_active;
                if (r_con_ok) begin
                    r_head[r_con] <= n_hd;
                    r_tail[r_con] <= n_tl;
                    r_nlc[r_con]  <= n_nl;
                    r_line[r_con] <= n_nl != '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= kcb_pkg::t_command'(i_command);
            r_code   <= i_scancode[6:0];
            r_rel    <= i_scancode[kcb_pkg::RELEASE_BIT];
            r_task   <= i_task_present;
            r_con    <= w_con;
            r_con_ok <= w_is_event || (w_is_pop && w_idx_ok);
            r_hd     <= r_head[w_con];
            r_tl     <= r_tail[w_con];
            r_nl     <= r_nlc[w_con];
        end
        if (r_busy) begin
            r_echo_valid   <= n_echo_valid;
            r_echo_char    <= n_echo_char;
            r_erase        <= n_erase;
            r_wake         <= n_wake;
            r_kill         <= n_kill;
            r_switch_valid <= n_switch_valid;
            r_switch_con   <= n_switch_con;
            r_pop_valid    <= n_pop_valid;
            r_pop_data     <= n_pop_data;
            r_line_ready   <= n_line_ready;
        end
    end

    assign busy             = r_busy;
    assign o_result_strobe  = r_strobe;
    assign o_echo_valid     = r_echo_valid;
    assign o_echo_char      = r_echo_char;
    assign o_erase_request  = r_erase;
    assign o_wake_reader    = r_wake;
    assign o_kill_request   = r_kill;
    assign o_switch_valid   = r_switch_valid;
    assign o_switch_console = r_switch_con;
    assign o_pop_valid      = r_pop_valid;
    assign o_pop_data       = r_pop_data;
    assign o_line_ready     = r_line_ready;

endmodule

[rtl/kcb_checker.sv]
// Port-level checks for the keyboard console buffer, bound to the top level.
`include "keyboard_console_buffer_unit_defines.svh"

module kcb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_result_strobe,
    input logic       o_echo_valid,
    input logic [6:0] o_echo_char,
    input logic       o_erase_request,
    input logic       o_wake_reader,
    input logic       o_kill_request,
    input logic       o_switch_valid,
    input logic       o_pop_valid,
    input logic       o_line_ready
);

    logic [4:0] w_actions;
    logic       w_echo_seen;
    logic       w_wake_seen;

    assign w_actions   = {o_echo_valid, o_erase_request, o_kill_request, o_switch_valid,
                          o_pop_valid};
    assign w_echo_seen = o_result_strobe && o_echo_valid;
    assign w_wake_seen = o_result_strobe && o_wake_reader;

    `KCB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `KCB_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_result_strobe && !busy)
    `KCB_ASSERT_SAME(a_one_action, i_clk, i_rst_n, o_result_strobe, $countones(w_actions) <= 1)
    `KCB_ASSERT_SAME(a_echo_nonzero, i_clk, i_rst_n, w_echo_seen, o_echo_char != 7'd0)
    `KCB_ASSERT_SAME(a_wake_line, i_clk, i_rst_n, w_wake_seen, o_echo_valid && o_line_ready)

endmodule

bind keyboard_console_buffer_unit kcb_checker u_kcb_checker (.*);
